/* design/ldcp_pkg.sv */
// ----------------------------------------------------------------------------
// ldcp_pkg
// Shared types and constants for the least-deflection corner picker.
// ----------------------------------------------------------------------------
package ldcp_pkg;

  localparam int COORD_BITS = 24;
  localparam int SINE_FRAC_BITS = 15;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int SINE_BITS = SINE_FRAC_BITS + 2;
  localparam int ROOT_STEPS = DIFF_BITS;
  localparam int DIV_STEPS = SINE_FRAC_BITS + 1;
  localparam int IN_DATA_BITS = 6 * COORD_BITS;
  localparam int OUT_DATA_BITS = 2 * COORD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQ_A,
    ST_SQ_B,
    ST_ROOT,
    ST_CHK,
    ST_DIV_A,
    ST_DIV_B,
    ST_CROSS_A,
    ST_CROSS_B,
    ST_UPDATE,
    ST_OUT
  } ldcp_state_e;

endpackage

/* design/least_deflection_corner_pick.sv */
// ----------------------------------------------------------------------------
// least_deflection_corner_pick
// Picks the silhouette corner that bends a path least.
// ----------------------------------------------------------------------------
// Usage: each request on the slave stream carries one corner together with
// the path start and destination; tlast marks the last corner of a
// silhouette and tuser flags a later path segment. For every corner the
// block computes the sine between start->destination and start->corner and
// tracks the best corner on each side. On the last corner one result leaves
// on the master stream: the waypoint in tdata, the corrected flag in tuser.
// s_axis_tready_o stays low from acceptance until a corner is done: each
// vector goes through a square root and two divisions on one shared
// subtract-compare unit, plus squaring and cross product steps on a shared
// multiplier. A zero-length vector skips its divisions, so such a corner
// finishes sooner. The result becomes valid once its last corner is done
// and the output register is free. s_axis_tready_o is high only between
// corners. A result waits in its output register while the receiver stalls;
// the next corner is still taken and worked on, and only its own result
// waits for the slot. Reset clears the tracking state and empties the
// output register.
// ----------------------------------------------------------------------------
module least_deflection_corner_pick (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // start_x, start_y, dest_x, dest_y, corner_x, corner_y
  input  logic [ldcp_pkg::IN_DATA_BITS-1:0]      s_axis_tdata_i,
  // later_segment
  input  logic                                   s_axis_tuser_i,
  input  logic                                   s_axis_tlast_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // waypoint_x, waypoint_y
  output logic [ldcp_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata_o,
  // corrected
  output logic                                   m_axis_tuser_o
);
  import ldcp_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DB = DIFF_BITS;
  localparam int SB = SINE_BITS;
  localparam int QB = SINE_FRAC_BITS + 1;
  localparam int RB = DB + 1;
  localparam int RADB = 2 * DB;
  localparam int XB = 2 * SB;
  localparam int CNTB = $clog2(ROOT_STEPS);

  ldcp_state_e state_q, state_d;

  // Input request registers.
  logic signed [DB-1:0] dx_q, dy_q, tx_q, ty_q;
  logic signed [CB-1:0] dest_x_q, dest_y_q, cor_x_q, cor_y_q;
  logic later_q, last_q;

  // Shared datapath registers.
  logic vec_q, zero_q;
  logic [DB-1:0] mag_a_q, mag_b_q;
  logic neg_a_q, neg_b_q;
  logic [RADB-1:0] sq_q, rad_q;
  logic [RB-1:0] rem_q;
  logic [DB-1:0] root_q;
  logic [QB-1:0] quot_q;
  logic [CNTB-1:0] cnt_q;
  logic signed [SB-1:0] ux_q, uy_q, vx_q, vy_q;
  logic signed [XB-1:0] cross_q;

  // Tracking state.
  logic signed [SB-1:0] best_l_q, best_r_q;
  logic signed [CB-1:0] l_x_q, l_y_q, r_x_q, r_y_q;

  // Output register.
  logic m_valid_q, m_corr_q;
  logic signed [CB-1:0] m_x_q, m_y_q;

  logic in_acc, out_load, last_step;

  // Handshake and step control.
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    in_acc = s_axis_tvalid_i && s_axis_tready_o;
    out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready_i);
    last_step = (cnt_q == '0);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_acc) state_d = ST_LOAD;
      ST_LOAD:    state_d = ST_SQ_A;
      ST_SQ_A:    state_d = ST_SQ_B;
      ST_SQ_B:    state_d = ST_ROOT;
      ST_ROOT:    if (last_step) state_d = ST_CHK;
      ST_CHK:     state_d = (root_q == '0) ? ST_CROSS_A : ST_DIV_A;
      ST_DIV_A:   if (last_step) state_d = ST_DIV_B;
      ST_DIV_B:   if (last_step) state_d = vec_q ? ST_CROSS_A : ST_LOAD;
      ST_CROSS_A: state_d = ST_CROSS_B;
      ST_CROSS_B: state_d = ST_UPDATE;
      ST_UPDATE:  state_d = last_q ? ST_OUT : ST_IDLE;
      ST_OUT:     if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Shared subtract-compare unit: square root digit or division step.
  logic [RB+1:0] sub_a, sub_b;
  logic [RB+2:0] sub_diff;
  logic sub_ge;
  always_comb begin
    if (state_q == ST_ROOT) begin
      sub_a = {rem_q, rad_q[RADB-1 -: 2]};
      sub_b = {1'b0, root_q, 2'b01};
    end else if (cnt_q == CNTB'(DIV_STEPS - 1)) begin
      sub_a = {2'b00, rem_q};
      sub_b = {3'b000, root_q};
    end else begin
      sub_a = {1'b0, rem_q, 1'b0};
      sub_b = {3'b000, root_q};
    end
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge = !sub_diff[RB+2];
  end

  // Shared multiplier: squares, then the two cross products.
  logic signed [DB:0] mul_a, mul_b;
  logic signed [2*DB+1:0] prod;
  always_comb begin
    case (state_q)
      ST_SQ_A: begin
        mul_a = {1'b0, mag_a_q};
        mul_b = {1'b0, mag_a_q};
      end
      ST_SQ_B: begin
        mul_a = {1'b0, mag_b_q};
        mul_b = {1'b0, mag_b_q};
      end
      ST_CROSS_A: begin
        mul_a = (DB+1)'(ux_q);
        mul_b = (DB+1)'(vy_q);
      end
      default: begin
        mul_a = (DB+1)'(uy_q);
        mul_b = (DB+1)'(vx_q);
      end
    endcase
    prod = mul_a * mul_b;
  end

  // Quotient with the new bit, and the signed unit component.
  logic [QB-1:0] quot_n;
  logic signed [SB-1:0] comp_a, comp_b;
  always_comb begin
    quot_n = {quot_q[QB-2:0], sub_ge};
    comp_a = neg_a_q ? -$signed({1'b0, quot_n}) : $signed({1'b0, quot_n});
    comp_b = neg_b_q ? -$signed({1'b0, quot_n}) : $signed({1'b0, quot_n});
  end

  // Sine from the cross product, truncated toward zero and saturated.
  logic [XB-1:0] cross_mag;
  logic [XB-SINE_FRAC_BITS-1:0] sine_mag;
  logic signed [SB-1:0] sine;
  always_comb begin
    cross_mag = cross_q[XB-1] ? XB'(-cross_q) : XB'(cross_q);
    sine_mag = cross_mag[XB-1:SINE_FRAC_BITS];
    if (zero_q) begin
      sine = '0;
    end else if (cross_q[XB-1]) begin
      sine = -$signed(SB'(sine_mag));
    end else if (sine_mag > (XB-SINE_FRAC_BITS)'({1'b0, {(SB-1){1'b1}}})) begin
      sine = {1'b0, {(SB-1){1'b1}}};
    end else begin
      sine = $signed(SB'(sine_mag));
    end
  end

  // Result choice from the tracked sides.
  logic res_corr, res_left;
  always_comb begin
    res_corr = !later_q && (best_l_q != '0) && (best_r_q != '0);
    res_left = $signed({best_l_q[SB-1], best_l_q}) < -$signed({best_r_q[SB-1], best_r_q});
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q <= DB'($signed(s_axis_tdata_i[3*CB-1:2*CB])) - DB'($signed(s_axis_tdata_i[CB-1:0]));
      dy_q <= DB'($signed(s_axis_tdata_i[4*CB-1:3*CB])) - DB'($signed(s_axis_tdata_i[2*CB-1:CB]));
      tx_q <= DB'($signed(s_axis_tdata_i[5*CB-1:4*CB])) - DB'($signed(s_axis_tdata_i[CB-1:0]));
      ty_q <= DB'($signed(s_axis_tdata_i[6*CB-1:5*CB])) - DB'($signed(s_axis_tdata_i[2*CB-1:CB]));
      dest_x_q <= s_axis_tdata_i[3*CB-1:2*CB];
      dest_y_q <= s_axis_tdata_i[4*CB-1:3*CB];
      cor_x_q <= s_axis_tdata_i[5*CB-1:4*CB];
      cor_y_q <= s_axis_tdata_i[6*CB-1:5*CB];
      later_q <= s_axis_tuser_i;
      last_q <= s_axis_tlast_i;
      vec_q <= 1'b0;
      zero_q <= 1'b0;
    end
    unique case (state_q)
      ST_LOAD: begin
        neg_a_q <= vec_q ? tx_q[DB-1] : dx_q[DB-1];
        neg_b_q <= vec_q ? ty_q[DB-1] : dy_q[DB-1];
        mag_a_q <= vec_q ? (tx_q[DB-1] ? DB'(-tx_q) : DB'(tx_q))
                         : (dx_q[DB-1] ? DB'(-dx_q) : DB'(dx_q));
        mag_b_q <= vec_q ? (ty_q[DB-1] ? DB'(-ty_q) : DB'(ty_q))
                         : (dy_q[DB-1] ? DB'(-dy_q) : DB'(dy_q));
      end
      ST_SQ_A: sq_q <= RADB'(prod);
      ST_SQ_B: begin
        rad_q <= sq_q + RADB'(prod);
        rem_q <= '0;
        root_q <= '0;
        cnt_q <= CNTB'(ROOT_STEPS - 1);
      end
      ST_ROOT: begin
        rad_q <= {rad_q[RADB-3:0], 2'b00};
        rem_q <= sub_ge ? sub_diff[RB-1:0] : sub_a[RB-1:0];
        root_q <= {root_q[DB-2:0], sub_ge};
        cnt_q <= cnt_q - 1'b1;
      end
      ST_CHK: begin
        if (root_q == '0) zero_q <= 1'b1;
        rem_q <= {1'b0, mag_a_q};
        quot_q <= '0;
        cnt_q <= CNTB'(DIV_STEPS - 1);
      end
      ST_DIV_A: begin
        if (last_step) begin
          if (vec_q) vx_q <= comp_a;
          else ux_q <= comp_a;
          rem_q <= {1'b0, mag_b_q};
          quot_q <= '0;
          cnt_q <= CNTB'(DIV_STEPS - 1);
        end else begin
          rem_q <= sub_ge ? sub_diff[RB-1:0] : sub_a[RB-1:0];
          quot_q <= quot_n;
          cnt_q <= cnt_q - 1'b1;
        end
      end
      ST_DIV_B: begin
        rem_q <= sub_ge ? sub_diff[RB-1:0] : sub_a[RB-1:0];
        quot_q <= quot_n;
        cnt_q <= cnt_q - 1'b1;
        if (last_step) begin
          if (vec_q) vy_q <= comp_b;
          else uy_q <= comp_b;
          vec_q <= 1'b1;
        end
      end
      ST_CROSS_A: cross_q <= XB'(prod);
      ST_CROSS_B: cross_q <= cross_q - XB'(prod);
      default: ;
    endcase
  end

  // Tracking state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_l_q <= '0;
      best_r_q <= '0;
      l_x_q <= '0;
      l_y_q <= '0;
      r_x_q <= '0;
      r_y_q <= '0;
      m_valid_q <= 1'b0;
      m_corr_q <= 1'b0;
      m_x_q <= '0;
      m_y_q <= '0;
    end else begin
      if (out_load) m_valid_q <= 1'b1;
      else if (m_valid_q && m_axis_tready_i) m_valid_q <= 1'b0;
      if (state_q == ST_UPDATE) begin
        if (sine > best_l_q) begin
          best_l_q <= sine;
          l_x_q <= cor_x_q;
          l_y_q <= cor_y_q;
        end else if (sine < best_r_q) begin
          best_r_q <= sine;
          r_x_q <= cor_x_q;
          r_y_q <= cor_y_q;
        end
      end
      if (out_load) begin
        m_corr_q <= res_corr;
        m_x_q <= !res_corr ? dest_x_q : (res_left ? l_x_q : r_x_q);
        m_y_q <= !res_corr ? dest_y_q : (res_left ? l_y_q : r_y_q);
        best_l_q <= '0;
        best_r_q <= '0;
        l_x_q <= '0;
        l_y_q <= '0;
        r_x_q <= '0;
        r_y_q <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o = {m_y_q, m_x_q};
  assign m_axis_tuser_o = m_corr_q;

`ifndef SYNTH
  // An accepted corner always starts with loading the first vector.
  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_LOAD) else $error("accepted corner did not start");
  // Division never runs against a zero length.
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_A || state_q == ST_DIV_B) |-> root_q != '0)
    else $error("division by zero length");
  // Emitting a result clears the tracking state.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (best_l_q == '0 && best_r_q == '0)) else $error("state not cleared");
  // A corrected result needs corners on both sides.
  a_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_corr) |-> (best_l_q > 0 && best_r_q < 0))
    else $error("correction without both sides");
`endif

endmodule

/* tb/sv/tb_least_deflection_corner_pick.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_least_deflection_corner_pick
// Self-checking testbench for the least-deflection corner picker.
// ----------------------------------------------------------------------------
// Corners come in directed and random silhouettes. A predictor in the
// testbench works out the sine of every corner, tracks the best corner on
// each side and, on the last corner, queues the expected waypoint. Results
// from the block are checked in order against that queue. The sender pauses
// in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_least_deflection_corner_pick;
  import ldcp_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int FB = SINE_FRAC_BITS;
  localparam int IDLE_LIMIT = 20000;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    logic   corrected;
    coord_t wx;
    coord_t wy;
  } waypoint_t;

  int fail_count = 0;

  // Prints one line per mismatch and counts it.
  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Scoreboard: tracks the silhouette and holds the expected waypoints.
  class waypoint_scoreboard;
    longint left_sine, right_sine;
    coord_t lx, ly, rx, ry;
    waypoint_t pending[$];

    function new();
      left_sine = 0; right_sine = 0;
      lx = 0; ly = 0; rx = 0; ry = 0;
    endfunction

    function automatic longint unsigned root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Unit vector in Q1.F; returns 0 on a zero-length vector.
    function automatic bit unit_vec(longint a, longint b, output longint ua,
                                    output longint ub);
      longint unsigned ma, mb, len, qa, qb, one;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      one = 64'd1 << FB;
      ua = 0; ub = 0;
      if (ma >= (64'd1 << 31) || mb >= (64'd1 << 31)) begin
        ma >>= 1; mb >>= 1;
      end
      len = root(ma * ma + mb * mb);
      if (len == 0) return 0;
      qa = (ma << FB) / len;
      qb = (mb << FB) / len;
      if (qa > one) qa = one;
      if (qb > one) qb = one;
      ua = a < 0 ? -longint'(qa) : longint'(qa);
      ub = b < 0 ? -longint'(qb) : longint'(qb);
      return 1;
    endfunction

    function automatic longint deflection_sine(longint dx, longint dy,
                                               longint tx, longint ty);
      longint ux, uy, vx, vy, cr, s, top;
      longint unsigned m;
      top = 64'sd1 <<< (FB + 1);
      if (!unit_vec(dx, dy, ux, uy) || !unit_vec(tx, ty, vx, vy)) return 0;
      cr = ux * vy - uy * vx;
      m = (cr < 0 ? -cr : cr) >> FB;
      s = cr < 0 ? -longint'(m) : longint'(m);
      if (s > top - 1) s = top - 1;
      if (s < -top) s = -top;
      return s;
    endfunction

    // Notes one accepted corner.
    function void note_corner(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                              coord_t cx, coord_t cy, bit later, bit last);
      longint s;
      waypoint_t w;
      s = deflection_sine(longint'(ex) - sx, longint'(ey) - sy,
                          longint'(cx) - sx, longint'(cy) - sy);
      if (s > left_sine) begin
        left_sine = s; lx = cx; ly = cy;
      end else if (s < right_sine) begin
        right_sine = s; rx = cx; ry = cy;
      end
      if (!last) return;
      w.corrected = 0; w.wx = ex; w.wy = ey;
      if (!later && left_sine != 0 && right_sine != 0) begin
        w.corrected = 1;
        if (left_sine < -right_sine) begin
          w.wx = lx; w.wy = ly;
        end else begin
          w.wx = rx; w.wy = ry;
        end
      end
      pending.push_back(w);
      left_sine = 0; right_sine = 0;
      lx = 0; ly = 0; rx = 0; ry = 0;
    endfunction

    // Checks one accepted result against the oldest expectation.
    task check_result(logic corr, coord_t wx, coord_t wy);
      waypoint_t w;
      if (pending.size() == 0) begin
        report("result with no expected waypoint");
        return;
      end
      w = pending.pop_front();
      if (corr !== w.corrected)
        report($sformatf("corrected %0b, expected %0b", corr, w.corrected));
      if (wx !== w.wx)
        report($sformatf("waypoint_x %0d, expected %0d", wx, w.wx));
      if (wy !== w.wy)
        report($sformatf("waypoint_y %0d, expected %0d", wy, w.wy));
    endtask
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid_i, s_axis_tready_o, s_axis_tuser_i, s_axis_tlast_i;
  logic [IN_DATA_BITS-1:0] s_axis_tdata_i;
  logic m_axis_tvalid_o, m_axis_tready_i, m_axis_tuser_o;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata_o;

  least_deflection_corner_pick dut (.*);

  waypoint_scoreboard sb = new();
  int idle_cycles = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Sends one corner request and waits for its acceptance.
  task automatic send_corner(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                             coord_t cx, coord_t cy, bit later, bit last);
    s_axis_tdata_i  <= {cy, cx, ey, ex, sy, sx};
    s_axis_tuser_i  <= later;
    s_axis_tlast_i  <= last;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_corner(sx, sy, ex, ey, cx, cy, later, last);
  endtask

  task automatic pause(int n);
    s_axis_tvalid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic coord_t rnd_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return {1'b0, {(CB-1){1'b1}}};
      2: return {1'b1, {(CB-1){1'b0}}};
      default: return coord_t'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  // Receiver stalls on its own repeating pattern with quiet stretches.
  initial begin
    int cyc;
    cyc = 0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if ((cyc / 3000) % 3 == 2) m_axis_tready_i <= 1'b1;
      else m_axis_tready_i <= ((cyc % 7) < 4) || ((cyc % 61) > 50);
    end
  end

  // Checks results and watches for a stalled run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tuser_o, coord_t'(m_axis_tdata_o[CB-1:0]),
                        coord_t'(m_axis_tdata_o[2*CB-1:CB]));
      if ((s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    coord_t sx, sy, ex, ey;
    coord_t mx, mn;
    int n_sent, len, burst;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    rst_ni = 0;
    s_axis_tvalid_i = 0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 0;
    s_axis_tlast_i = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: left and right corners, ties, zero-length vectors, extremes.
    send_corner(0, 0, 1000, 0, 500, 300, 0, 0);
    send_corner(0, 0, 1000, 0, 500, -200, 0, 0);
    send_corner(0, 0, 1000, 0, 500, 300, 0, 1);
    send_corner(0, 0, 1000, 0, 500, 300, 0, 0);
    send_corner(0, 0, 1000, 0, 500, -300, 0, 1);
    send_corner(0, 0, 1000, 0, 500, 300, 1, 0);
    send_corner(0, 0, 1000, 0, 500, -300, 1, 1);
    send_corner(0, 0, 1000, 0, 500, 300, 0, 1);
    send_corner(10, 10, 10, 10, 500, 300, 0, 1);
    send_corner(10, 10, 50, 20, 10, 10, 0, 1);
    send_corner(mn, mn, mx, mx, mx, mn, 0, 0);
    send_corner(mn, mn, mx, mx, mn, mx, 0, 1);
    send_corner(mx, mx, mn, mn, mn, mx, 0, 0);
    send_corner(mx, mn, mn, mx, mx, mx, 0, 1);
    send_corner(0, 0, -1, -1, 1, -1, 0, 0);
    send_corner(5, 5, 9, 9, -1, 1, 0, 0);
    send_corner(0, 0, 100, 0, 100, 1, 0, 1);
    send_corner(0, 0, 1000, 0, -5, 0, 0, 1);
    s_axis_tvalid_i <= 0;

    // Random silhouettes, sent in bursts with gaps.
    n_sent = 0;
    burst = 0;
    while (n_sent < 800) begin
      sx = rnd_coord(); sy = rnd_coord();
      ex = rnd_coord(); ey = rnd_coord();
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if (burst == 0) begin
          pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200));
          burst = $urandom_range(1, 12);
        end
        burst--;
        if ($urandom_range(0, 19) == 0) begin
          sx = rnd_coord(); ex = rnd_coord();
        end
        send_corner(sx, sy, ex, ey, rnd_coord(), rnd_coord(),
                    $urandom_range(0, 4) == 0, i == len - 1);
        n_sent++;
      end
    end
    s_axis_tvalid_i <= 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
